[design/mvt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the 4x4 matrix by 4-vector transform.
package mvt_pkg;

  localparam int unsigned FieldW   = 32;  // width of every vector field on the ports
  localparam int unsigned NumComp  = 4;   // components per vector, also rows per matrix
  localparam int unsigned NumRegs  = 8;   // two registers per matrix column
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned HalfW    = 32;  // one matrix entry per register half

  typedef struct packed {
    logic signed [FieldW-1:0] x_in;
    logic signed [FieldW-1:0] y_in;
    logic signed [FieldW-1:0] z_in;
    logic signed [FieldW-1:0] w_in;
  } vec_in_t;

  typedef struct packed {
    logic signed [FieldW-1:0] x_out;
    logic signed [FieldW-1:0] y_out;
    logic signed [FieldW-1:0] z_out;
    logic signed [FieldW-1:0] w_out;
    logic                     saturated;
  } vec_out_t;

  // load strobes for the three lane pipeline registers
  typedef struct packed {
    logic ld_prod;
    logic ld_pair;
    logic ld_sum;
  } lane_ctrl_t;

endpackage

[design/mvt_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one payload beat.
interface mvt_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/mat4_vec4_transform.sv]
`timescale 1ns / 1ps
// Pipeline: each beat passes through the product, pair-sum, final-sum and output registers.
// Throughput: one vector per cycle while out_if is ready; four row lanes each run four 32x32 multipliers.
// Ready chains back from the output register; input stalls only once all four stages hold beats.
// Reset (async, active low) clears all matrix registers to zero and empties the pipeline.
// The user must write matrix registers only while the pipeline is empty; the block does not enforce it.
module mat4_vec4_transform #(
  parameter int unsigned COMPONENT_WIDTH = 32,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mvt_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [mvt_pkg::CfgDataW-1:0]    cfg_data_i,
  mvt_stream_if.sink                      in_if,
  mvt_stream_if.source                    out_if
);

  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned SW = 2 * CW + 2;

  logic [mvt_pkg::CfgDataW-1:0] mat_q [mvt_pkg::NumRegs];
  logic signed [CW-1:0] vec [mvt_pkg::NumComp];
  logic signed [CW-1:0] row_ent [mvt_pkg::NumComp][mvt_pkg::NumComp];
  logic signed [SW-1:0] lane_sum [mvt_pkg::NumComp];

  logic v_prod_q, v_pair_q, v_sum_q;
  logic adv_prod, adv_pair, adv_sum, load_ok;
  mvt_pkg::lane_ctrl_t lane_ctrl;

  // matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mvt_pkg::NumRegs; i++) begin
        mat_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign vec[0] = in_if.data.x_in[CW-1:0];
  assign vec[1] = in_if.data.y_in[CW-1:0];
  assign vec[2] = in_if.data.z_in[CW-1:0];
  assign vec[3] = in_if.data.w_in[CW-1:0];

  // entry(c,r): register 2c + r/2, half r%2
  for (genvar r = 0; r < mvt_pkg::NumComp; r++) begin : g_row
    for (genvar c = 0; c < mvt_pkg::NumComp; c++) begin : g_col
      assign row_ent[r][c] = mat_q[2*c + r/2][(r%2)*mvt_pkg::HalfW +: CW];
    end
  end

  // stage advance chain, back from the output register
  assign adv_sum  = !v_sum_q  || load_ok;
  assign adv_pair = !v_pair_q || adv_sum;
  assign adv_prod = !v_prod_q || adv_pair;

  assign in_if.ready = adv_prod;

  assign lane_ctrl.ld_prod = adv_prod && in_if.valid;
  assign lane_ctrl.ld_pair = adv_pair && v_prod_q;
  assign lane_ctrl.ld_sum  = adv_sum  && v_pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_prod_q <= 1'b0;
      v_pair_q <= 1'b0;
      v_sum_q  <= 1'b0;
    end else begin
      if (adv_prod) v_prod_q <= in_if.valid;
      if (adv_pair) v_pair_q <= v_prod_q;
      if (adv_sum)  v_sum_q  <= v_pair_q;
    end
  end

  for (genvar r = 0; r < mvt_pkg::NumComp; r++) begin : g_lane
    mvt_lane #(
      .CW (CW)
    ) u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .vec_i  (vec),
      .row_i  (row_ent[r]),
      .sum_o  (lane_sum[r])
    );
  end

  mvt_merge #(
    .CW (CW),
    .FB (FRAC_BITS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v_sum_q),
    .sum_i     (lane_sum),
    .load_ok_o (load_ok),
    .out_if    (out_if)
  );

endmodule

[design/mvt_lane.sv]
`timescale 1ns / 1ps
// One row lane: four products, pairwise add, final sum.
module mvt_lane #(
  parameter int unsigned CW = 32
) (
  input  logic                   clk_i,
  input  mvt_pkg::lane_ctrl_t    ctrl_i,
  input  logic signed [CW-1:0]   vec_i [mvt_pkg::NumComp],
  input  logic signed [CW-1:0]   row_i [mvt_pkg::NumComp],
  output logic signed [2*CW+1:0] sum_o
);

  localparam int unsigned PW = 2 * CW;

  logic signed [PW-1:0] prod_q [mvt_pkg::NumComp];
  logic signed [PW:0]   pair_q [2];
  logic signed [PW+1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod) begin
      for (int c = 0; c < mvt_pkg::NumComp; c++) begin
        prod_q[c] <= row_i[c] * vec_i[c];
      end
    end
    if (ctrl_i.ld_pair) begin
      pair_q[0] <= (PW+1)'(prod_q[0]) + (PW+1)'(prod_q[1]);
      pair_q[1] <= (PW+1)'(prod_q[2]) + (PW+1)'(prod_q[3]);
    end
    if (ctrl_i.ld_sum) begin
      sum_q <= (PW+2)'(pair_q[0]) + (PW+2)'(pair_q[1]);
    end
  end

  assign sum_o = sum_q;

endmodule

[design/mvt_merge.sv]
`timescale 1ns / 1ps
// Merge stage: scale, saturate and flag the four lane sums into the output register.
module mvt_merge #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [2*CW+1:0] sum_i [mvt_pkg::NumComp],
  output logic                   load_ok_o,
  mvt_stream_if.source           out_if
);

  localparam int unsigned SW = 2 * CW + 2;

  logic signed [SW-1:0] shr      [mvt_pkg::NumComp];
  logic signed [CW-1:0] clip     [mvt_pkg::NumComp];
  logic [mvt_pkg::NumComp-1:0] sat_row;
  logic signed [CW-1:0] hi_lim;
  logic signed [CW-1:0] lo_lim;
  mvt_pkg::vec_out_t    out_d, out_q;
  logic                 out_valid_q;

  assign hi_lim = {1'b0, {(CW-1){1'b1}}};
  assign lo_lim = {1'b1, {(CW-1){1'b0}}};

  // floor shift, then the value fits iff all bits from CW-1 upward agree
  always_comb begin
    for (int r = 0; r < mvt_pkg::NumComp; r++) begin
      shr[r]     = sum_i[r] >>> FB;
      sat_row[r] = !((&shr[r][SW-1:CW-1]) || !(|shr[r][SW-1:CW-1]));
      if (sat_row[r]) begin
        clip[r] = shr[r][SW-1] ? lo_lim : hi_lim;
      end else begin
        clip[r] = shr[r][CW-1:0];
      end
    end
    out_d.x_out     = mvt_pkg::FieldW'(clip[0]);
    out_d.y_out     = mvt_pkg::FieldW'(clip[1]);
    out_d.z_out     = mvt_pkg::FieldW'(clip[2]);
    out_d.w_out     = mvt_pkg::FieldW'(clip[3]);
    out_d.saturated = |sat_row;
  end

  assign load_ok_o = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_ok_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok_o && valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

endmodule
